@@ rtl/core/pst_pkg.sv @@
package pst_pkg;

    // Fixed field widths
    localparam int SIDE_W   = 9;
    localparam int QUERY_W  = 16;

    // Side length limits
    localparam int SIDE_MIN     = 2;
    localparam int MAX_SIDE_DEF = 256;
    localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(256);

    // Commands from the controller to the datapath
    typedef struct packed {
        logic cfg_wr;     // latch a new side length
        logic fill_init;  // clear the sweep address
        logic fill_step;  // write one entry of the initial fill
        logic base_init;  // start the sieve at base two
        logic base_read;  // read the flag of the current base, square it
        logic base_next;  // advance to the next base
        logic mark_init;  // first multiple is base squared
        logic mark_step;  // clear one multiple, step by base
        logic query_rd;   // request accepted: read its flag
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic fill_last;   // sweep is at the last entry
        logic base_done;   // base squared reaches the table size
        logic base_prime;  // flag of the current base
        logic mark_last;   // next multiple falls outside the table
    } t_sts;

endpackage

@@ rtl/core/pst_ram.sv @@
module pst_ram import pst_pkg::*; #(
    parameter int WIDTH = 1,
    parameter int DEPTH = MAX_SIDE_DEF * MAX_SIDE_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, holds its data between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/pst_dp.sv @@
module pst_dp import pst_pkg::*; #(
    parameter int MAX_SIDE = MAX_SIDE_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic [SIDE_W-1:0]  i_side_length,
    input  logic [QUERY_W-1:0] i_query_number,
    output logic               o_is_prime,
    output logic               o_out_of_range
);

    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    // counters reach table size plus one base step
    localparam int CW    = $clog2(DEPTH + MAX_SIDE + 1);
    localparam int IW    = $clog2(MAX_SIDE + 1);
    localparam int CMPW  = (CW > QUERY_W) ? CW : QUERY_W;

    logic [SIDE_W-1:0] r_side;
    logic [SIDE_W-1:0] eff_side;
    logic [CW-1:0]     r_size;
    logic [CW-1:0]     r_mult;
    logic [IW-1:0]     r_base;
    logic [CW-1:0]     r_isq;
    logic              r_oor;
    logic [CW-1:0]     next_mult;
    logic              q_oor;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic              ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic              ram_rdata;

    // Side length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= SIDE_RESET;
        end else if (i_cmd.cfg_wr) begin
            r_side <= i_side_length;
        end
    end

    // Clamp the side and square it into the table size
    always_comb begin
        eff_side = r_side;
        if (r_side < SIDE_W'(SIDE_MIN)) eff_side = SIDE_W'(SIDE_MIN);
        if (r_side > SIDE_W'(MAX_SIDE)) eff_side = SIDE_W'(MAX_SIDE);
    end

    always_ff @(posedge i_clk) begin
        r_size <= CW'((2*SIDE_W)'(eff_side) * (2*SIDE_W)'(eff_side));
    end

    // Sweep / multiple address and base counters
    assign next_mult = r_mult + CW'(r_base);

    always_ff @(posedge i_clk) begin
        if (i_cmd.fill_init) begin
            r_mult <= '0;
        end else if (i_cmd.fill_step) begin
            r_mult <= r_mult + CW'(1);
        end else if (i_cmd.mark_init) begin
            r_mult <= r_isq;
        end else if (i_cmd.mark_step) begin
            r_mult <= next_mult;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.base_init) begin
            r_base <= IW'(2);
        end else if (i_cmd.base_next) begin
            r_base <= r_base + IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.base_read) begin
            r_isq <= CW'(r_base) * CW'(r_base);
        end
    end

    // Status back to the controller
    assign o_sts.fill_last  = (r_mult == r_size - CW'(1));
    assign o_sts.base_done  = (r_isq >= r_size);
    assign o_sts.base_prime = ram_rdata;
    assign o_sts.mark_last  = (next_mult >= r_size);

    // Table port control
    assign ram_we    = i_cmd.fill_step | i_cmd.mark_step;
    assign ram_waddr = r_mult[AW-1:0];
    assign ram_wdata = i_cmd.fill_step & (r_mult >= CW'(2));
    assign ram_re    = i_cmd.base_read | i_cmd.query_rd;
    assign ram_raddr = i_cmd.query_rd ? AW'(i_query_number) : AW'(r_base);

    pst_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Range check travels with the read
    assign q_oor = (CMPW'(i_query_number) >= CMPW'(r_size));

    always_ff @(posedge i_clk) begin
        if (i_cmd.query_rd) begin
            r_oor <= q_oor;
        end
    end

    assign o_out_of_range = r_oor;
    assign o_is_prime     = ram_rdata & ~r_oor;

endmodule

@@ rtl/core/pst_ctrl.sv @@
module pst_ctrl import pst_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_FILL     = 3'd1;
    localparam logic [2:0] S_BASE_RD  = 3'd2;
    localparam logic [2:0] S_BASE_CHK = 3'd3;
    localparam logic [2:0] S_MARK     = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_built;
    logic       n_built;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       in_ready;
    logic       cfg_ready;
    logic       accept;

    // Serve requests once the table is built; output register may drain same cycle
    assign in_ready    = (r_state == S_IDLE) && r_built && (!r_out_valid || i_out_ready);
    assign accept      = in_ready && i_in_valid;
    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;
    // Side writes only between builds
    assign cfg_ready   = (r_state == S_IDLE);
    assign o_cfg_ready = cfg_ready;

    // Build sequencer
    always_comb begin
        n_state      = r_state;
        n_built      = r_built;
        o_cmd        = '0;
        o_cmd.cfg_wr = i_cfg_valid && cfg_ready;
        o_cmd.query_rd = accept;
        unique case (r_state)
            S_IDLE: begin
                if (i_cfg_valid) begin
                    n_built = 1'b0;
                end else if (!r_built && i_in_valid && !r_out_valid) begin
                    o_cmd.fill_init = 1'b1;
                    n_state         = S_FILL;
                end
            end
            S_FILL: begin
                o_cmd.fill_step = 1'b1;
                if (i_sts.fill_last) begin
                    o_cmd.base_init = 1'b1;
                    n_state         = S_BASE_RD;
                end
            end
            S_BASE_RD: begin
                o_cmd.base_read = 1'b1;
                n_state         = S_BASE_CHK;
            end
            S_BASE_CHK: begin
                if (i_sts.base_done) begin
                    n_built = 1'b1;
                    n_state = S_IDLE;
                end else if (i_sts.base_prime) begin
                    o_cmd.mark_init = 1'b1;
                    n_state         = S_MARK;
                end else begin
                    o_cmd.base_next = 1'b1;
                    n_state         = S_BASE_RD;
                end
            end
            S_MARK: begin
                o_cmd.mark_step = 1'b1;
                if (i_sts.mark_last) begin
                    o_cmd.base_next = 1'b1;
                    n_state         = S_BASE_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Result valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (accept) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_built     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_built     <= n_built;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ rtl/core/prime_sieve_table_unit.sv @@
// Queries: one per cycle sustained while the receiver keeps up, result in the cycle after the request is taken.
// Build: the first request after reset or a side write waits for the sieve: a fill of
//   every entry, then for each base up to sqrt(size) a flag read and, for a prime base, a mark of
//   its multiples, through the single write port of the flag table, one entry per cycle.
// Reset: synchronous active-low; side length returns to 256, table marked unbuilt.
module prime_sieve_table_unit import pst_pkg::*; #(
    parameter int MAX_SIDE = MAX_SIDE_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [QUERY_W-1:0] i_query_number,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_is_prime,
    output logic               o_out_of_range,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [SIDE_W-1:0]  i_cfg_side_length
);

    t_cmd cmd;
    t_sts sts;

    // Sequencer and handshake control
    pst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Counters, flag table and result path
    pst_dp #(
        .MAX_SIDE (MAX_SIDE)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_side_length  (i_cfg_side_length),
        .i_query_number (i_query_number),
        .o_is_prime     (o_is_prime),
        .o_out_of_range (o_out_of_range)
    );

endmodule

@@ dv/prime_sieve_table_unit_test.sv @@
`timescale 1ns / 1ps

module prime_sieve_table_unit_test;
    import pst_pkg::*;

    localparam int WATCHDOG_LIMIT = 1_000_000;
    localparam int STALL_CYCLES   = 300;
    localparam int SETTLE_CYCLES  = 8;
    localparam int IDLE_PERCENT   = 18;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [QUERY_W-1:0] i_query_number;
    logic               o_out_valid;
    logic               i_out_ready;
    logic               o_is_prime;
    logic               o_out_of_range;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [SIDE_W-1:0]  i_cfg_side_length;

    typedef struct {
        logic [QUERY_W-1:0] number;
        logic               is_prime;
        logic               out_of_range;
    } t_answer;

    // Shadow of the block: side register and its own sieve table
    logic [SIDE_W-1:0] side_reg;
    bit                sieve_valid;
    int unsigned       sieve_span;
    bit                prime_flag_table [65536];
    t_answer           pending_answers [$];

    int  error_count;
    int  idle_cycles;
    int  stall_left;
    bit  stall_request;
    bit  steady_mode;

    prime_sieve_table_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_query_number    (i_query_number),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_is_prime        (o_is_prime),
        .o_out_of_range    (o_out_of_range),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_side_length (i_cfg_side_length)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Side after clamping, squared
    function automatic int unsigned sieve_span_of(input logic [SIDE_W-1:0] side);
        int unsigned s;
        s = side;
        if (s < SIDE_MIN) s = SIDE_MIN;
        if (s > MAX_SIDE_DEF) s = MAX_SIDE_DEF;
        return s * s;
    endfunction

    // Sieve of Eratosthenes over the current span
    function automatic void rebuild_sieve();
        int unsigned b;
        int unsigned m;
        sieve_span = sieve_span_of(side_reg);
        for (int unsigned i = 0; i < sieve_span; i++) prime_flag_table[i] = 1'b1;
        prime_flag_table[0] = 1'b0;
        prime_flag_table[1] = 1'b0;
        for (b = 2; b * b < sieve_span; b++) begin
            if (prime_flag_table[b]) begin
                for (m = b * b; m < sieve_span; m += b) prime_flag_table[m] = 1'b0;
            end
        end
        sieve_valid = 1'b1;
    endfunction

    // Expected answer for one accepted request
    function automatic t_answer predict_answer(input logic [QUERY_W-1:0] number);
        t_answer a;
        if (!sieve_valid) rebuild_sieve();
        a.number = number;
        if (number >= sieve_span) begin
            a.is_prime     = 1'b0;
            a.out_of_range = 1'b1;
        end else begin
            a.is_prime     = prime_flag_table[number];
            a.out_of_range = 1'b0;
        end
        return a;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    // Result checker
    always @(posedge i_clk) begin
        t_answer a;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_answers.size() == 0) begin
                report_mismatch("result with no request outstanding");
            end else begin
                a = pending_answers.pop_front();
                if (o_is_prime !== a.is_prime)
                    report_mismatch($sformatf("query %0d is_prime got %b want %b",
                                              a.number, o_is_prime, a.is_prime));
                if (o_out_of_range !== a.out_of_range)
                    report_mismatch($sformatf("query %0d out_of_range got %b want %b",
                                              a.number, o_out_of_range, a.out_of_range));
            end
        end
    end

    // Result receiver: random backpressure, long hold-off on request
    always @(negedge i_clk) begin
        if (stall_request) begin
            stall_left    = STALL_CYCLES;
            stall_request = 1'b0;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (steady_mode) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Send one query request; entered and left at a falling edge
    task automatic send_query(input logic [QUERY_W-1:0] number);
        // idle one cycle at a time, so each cycle idles at the set rate
        while (!steady_mode && $urandom_range(99) < IDLE_PERCENT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_query_number <= number;
        do @(posedge i_clk); while (!o_in_ready);
        pending_answers.push_back(predict_answer(number));
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every answer is back
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        while (pending_answers.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_side(input logic [SIDE_W-1:0] side);
        wait_for_drain();
        i_cfg_valid       <= 1'b1;
        i_cfg_side_length <= side;
        do @(posedge i_clk); while (!o_cfg_ready);
        side_reg    = side;
        sieve_valid = 1'b0;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly in range, with boundary, random and extreme numbers mixed in
    function automatic logic [QUERY_W-1:0] pick_query(input int unsigned span);
        int v;
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: v = $urandom_range(span - 1, 0);
            6: v = int'(span) - 2 + int'($urandom_range(3));
            7: v = $urandom_range(65535);
            8: v = $urandom_range(3);
            default: v = 65535;
        endcase
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return v[QUERY_W-1:0];
    endfunction

    // Reset side, full table: first request triggers the build
    task automatic test_default_side();
        send_query(16'd0);
        send_query(16'd1);
        send_query(16'd2);
        send_query(16'd3);
        send_query(16'd4);
        send_query(16'd65521);
        send_query(16'd65535);
        wait_for_drain();
    endtask

    // Sides below the minimum clamp to two, table of four entries
    task automatic test_small_side();
        write_side(9'd0);
        send_query(16'd0);
        send_query(16'd1);
        send_query(16'd2);
        send_query(16'd3);
        send_query(16'd4);
        send_query(16'd65535);
        write_side(9'd1);
        send_query(16'd3);
        send_query(16'd4);
        write_side(9'd2);
        send_query(16'd3);
        send_query(16'd4);
        wait_for_drain();
    endtask

    // Sides above the maximum clamp to the full table, rebuilt after rewrite
    task automatic test_large_side();
        write_side(9'd511);
        send_query(16'd65521);
        send_query(16'd65535);
        send_query(16'd257);
        wait_for_drain();
    endtask

    // Receiver holds off while requests keep coming, then sender pauses
    task automatic test_backpressure();
        write_side(9'd16);
        send_query(16'd0);
        stall_request = 1'b1;
        for (int n = 0; n < 40; n++) send_query(pick_query(sieve_span_of(9'd16)));
        wait_for_drain();
    endtask

    // Back-to-back requests with the receiver always ready
    task automatic test_steady_stream();
        write_side(9'd30);
        steady_mode = 1'b1;
        for (int n = 0; n < 100; n++) send_query(pick_query(sieve_span_of(9'd30)));
        wait_for_drain();
        steady_mode = 1'b0;
    endtask

    // Random sides, mostly small so builds stay short
    task automatic test_random_sides();
        int r;
        logic [SIDE_W-1:0] side;
        for (int phase = 0; phase < 8; phase++) begin
            r = $urandom_range(99);
            if (r < 5) side = $urandom_range(1, 0);
            else if (r < 12) side = SIDE_MIN;
            else if (r < 22) side = $urandom_range(160, 100);
            else side = $urandom_range(64, 3);
            write_side(side);
            for (int n = 0; n < 60; n++) send_query(pick_query(sieve_span_of(side)));
        end
        wait_for_drain();
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_in_valid        = 1'b0;
        i_query_number    = '0;
        i_out_ready       = 1'b0;
        i_cfg_valid       = 1'b0;
        i_cfg_side_length = '0;
        side_reg          = SIDE_RESET;
        sieve_valid       = 1'b0;
        sieve_span        = 0;
        error_count       = 0;
        idle_cycles       = 0;
        stall_left        = 0;
        stall_request     = 1'b0;
        steady_mode       = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_default_side();
        test_small_side();
        test_large_side();
        test_backpressure();
        test_steady_stream();
        test_random_sides();

        wait_for_drain();
        if (pending_answers.size() != 0)
            report_mismatch($sformatf("%0d answers never arrived", pending_answers.size()));
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
